// ----- sv/vra_pkg.sv -----
`timescale 1ns / 1ps
package vra_pkg;

  localparam logic MODE_EXPLICIT = 1'b0;
  localparam logic MODE_AXIS     = 1'b1;

  localparam logic [2:0] AXIS_POS_Y = 3'd0;
  localparam logic [2:0] AXIS_NEG_Y = 3'd1;
  localparam logic [2:0] AXIS_NEG_X = 3'd2;
  localparam logic [2:0] AXIS_POS_X = 3'd3;

endpackage

// ----- sv/vra_div.sv -----
`timescale 1ns / 1ps
// One quotient bit per stage, MSB first; remainder left for rounding.
module vra_div #(
  parameter int NW   = 73,
  parameter int DENW = 48,
  parameter int QB   = 26,
  parameter int SW   = 25
) (
  input  logic            clk,
  input  logic [QB-1:0]   en,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  input  logic [SW-1:0]   side,
  output logic [NW-1:0]   rem_o,
  output logic [QB-1:0]   quo_o,
  output logic [DENW-1:0] den_o,
  output logic [SW-1:0]   side_o
);

  logic [NW-1:0]   rem [QB];
  logic [QB-1:0]   quo [QB];
  logic [DENW-1:0] dd  [QB];
  logic [SW-1:0]   sd  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_st
    logic [NW-1:0]   r_in;
    logic [QB-1:0]   q_in;
    logic [DENW-1:0] d_in;
    logic [SW-1:0]   s_in;
    logic [NW-1:0]   dsh;
    logic [NW:0]     diff;

    if (j == 0) begin : g_first
      assign r_in = num;
      assign q_in = '0;
      assign d_in = den;
      assign s_in = side;
    end else begin : g_rest
      assign r_in = rem[j-1];
      assign q_in = quo[j-1];
      assign d_in = dd[j-1];
      assign s_in = sd[j-1];
    end

    assign dsh  = NW'(d_in) << (QB - 1 - j);
    assign diff = {1'b0, r_in} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= diff[NW] ? r_in : diff[NW-1:0];
        quo[j] <= {q_in[QB-2:0], ~diff[NW]};
        dd[j]  <= d_in;
        sd[j]  <= s_in;
      end
    end
  end

  assign rem_o  = rem[QB-1];
  assign quo_o  = quo[QB-1];
  assign den_o  = dd[QB-1];
  assign side_o = sd[QB-1];

endmodule

// ----- sv/vector_reflect_about_normal_top.sv -----
`timescale 1ns / 1ps
// Stages: input, products, dot, |dot|, partials, numerator, divider, round, output.
// One transaction per cycle unless stalled; one quotient bit per divider stage.
// Each stage holds while full and blocked, so bubbles close up under backpressure.
// Reset (rst, synchronous) empties every stage; payload registers are not reset.
module vector_reflect_about_normal_top #(
  parameter int COMP_BITS = 24,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic signed [COMP_BITS-1:0] dir_x,
  input  logic signed [COMP_BITS-1:0] dir_y,
  input  logic signed [COMP_BITS-1:0] dir_z,
  input  logic signed [COMP_BITS-1:0] norm_x,
  input  logic signed [COMP_BITS-1:0] norm_y,
  input  logic signed [COMP_BITS-1:0] norm_z,
  input  logic [2:0]                  axis_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COMP_BITS-1:0] out_x,
  output logic signed [COMP_BITS-1:0] out_y,
  output logic signed [COMP_BITS-1:0] out_z,
  output logic                        clipped
);
  import vra_pkg::*;

  localparam int W   = COMP_BITS;
  localparam int NW  = 3 * W + 1;
  localparam int QB  = W + 2;
  localparam int SW  = W + 1;
  localparam int DV  = 6;
  localparam int RS  = DV + QB;
  localparam int S   = QB + 8;

  localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [S:0]   ld;
  logic [S-1:0] vld;
  logic [S-1:0] vld_in;

  assign ld[S] = out_ready;
  for (genvar k = 0; k < S; k++) begin : g_ld
    assign ld[k] = ~vld[k] | ld[k+1];
  end

  assign vld_in = {vld[S-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (ld[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[S-1];

  // stage 0: input register with normal select
  logic signed [W-1:0] n_sel [3];
  logic signed [W-1:0] s0_v [3];
  logic signed [W-1:0] s0_n [3];

  always_comb begin
    n_sel[0] = '0;
    n_sel[1] = '0;
    n_sel[2] = '0;
    if (mode == MODE_EXPLICIT) begin
      n_sel[0] = norm_x;
      n_sel[1] = norm_y;
      n_sel[2] = norm_z;
    end else begin
      unique case (axis_code)
        AXIS_POS_Y: n_sel[1] = ONE;
        AXIS_NEG_Y: n_sel[1] = -ONE;
        AXIS_NEG_X: n_sel[0] = -ONE;
        AXIS_POS_X: n_sel[0] = ONE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_v[0] <= dir_x;
      s0_v[1] <= dir_y;
      s0_v[2] <= dir_z;
      s0_n    <= n_sel;
    end
  end

  // stage 1: products
  logic signed [W-1:0]   s1_v [3];
  logic signed [2*W-1:0] s1_p [3];
  logic signed [2*W-1:0] s1_sq [3];
  logic [W-1:0]          s1_nmag [3];
  logic [2:0]            s1_nneg;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_v[i]    <= s0_v[i];
        s1_p[i]    <= s0_v[i] * s0_n[i];
        s1_sq[i]   <= s0_n[i] * s0_n[i];
        s1_nmag[i] <= $unsigned(s0_n[i][W-1] ? -s0_n[i] : s0_n[i]);
        s1_nneg[i] <= s0_n[i][W-1];
      end
    end
  end

  // stage 2: dot product and squared length
  logic signed [W-1:0]   s2_v [3];
  logic signed [2*W+1:0] s2_dot;
  logic [2*W-1:0]        s2_nn;
  logic [W-1:0]          s2_nmag [3];
  logic [2:0]            s2_nneg;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_v    <= s1_v;
      s2_dot  <= (2*W+2)'(s1_p[0]) + (2*W+2)'(s1_p[1]) + (2*W+2)'(s1_p[2]);
      s2_nn   <= $unsigned(s1_sq[0]) + $unsigned(s1_sq[1]) + $unsigned(s1_sq[2]);
      s2_nmag <= s1_nmag;
      s2_nneg <= s1_nneg;
    end
  end

  // stage 3: magnitude of dot product
  logic signed [2*W+1:0] dot_abs;
  logic signed [W-1:0]   s3_v [3];
  logic [2*W-1:0]        s3_dmag;
  logic                  s3_dneg;
  logic [2*W-1:0]        s3_nn;
  logic [W-1:0]          s3_nmag [3];
  logic [2:0]            s3_nneg;

  assign dot_abs = s2_dot[2*W+1] ? -s2_dot : s2_dot;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_v    <= s2_v;
      s3_dmag <= dot_abs[2*W-1:0];
      s3_dneg <= s2_dot[2*W+1];
      s3_nn   <= s2_nn;
      s3_nmag <= s2_nmag;
      s3_nneg <= s2_nneg;
    end
  end

  // stage 4: partial products of |v.n| * |n_i|
  logic signed [W-1:0] s4_v [3];
  logic [2*W-1:0]      s4_pl [3];
  logic [2*W-1:0]      s4_ph [3];
  logic [2:0]          s4_tneg;
  logic [2*W-1:0]      s4_nn;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_v[i]    <= s3_v[i];
        s4_pl[i]   <= s3_dmag[W-1:0] * s3_nmag[i];
        s4_ph[i]   <= s3_dmag[2*W-1:W] * s3_nmag[i];
        s4_tneg[i] <= s3_dneg ^ s3_nneg[i];
      end
      s4_nn <= s3_nn;
    end
  end

  // stage 5: numerator 2*|v.n|*|n_i|; zero normal divides 0 by 1
  logic signed [W-1:0] s5_v [3];
  logic [NW-1:0]       s5_num [3];
  logic [2*W-1:0]      s5_den;
  logic [2:0]          s5_tneg;
  logic                nn_zero;

  assign nn_zero = (s4_nn == '0);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int i = 0; i < 3; i++) begin
        s5_v[i]   <= s4_v[i];
        s5_num[i] <= nn_zero ? '0
                   : (NW'({s4_ph[i], {W{1'b0}}}) + NW'(s4_pl[i])) << 1;
      end
      s5_den  <= nn_zero ? (2*W)'(1) : s4_nn;
      s5_tneg <= s4_tneg;
    end
  end

  // divider lanes
  logic [NW-1:0]  d_rem  [3];
  logic [QB-1:0]  d_quo  [3];
  logic [2*W-1:0] d_den  [3];
  logic [SW-1:0]  d_side [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vra_div #(
      .NW  (NW),
      .DENW(2 * W),
      .QB  (QB),
      .SW  (SW)
    ) u_div (
      .clk   (clk),
      .en    (ld[RS-1:DV]),
      .num   (s5_num[i]),
      .den   (s5_den),
      .side  ({s5_tneg[i], s5_v[i]}),
      .rem_o (d_rem[i]),
      .quo_o (d_quo[i]),
      .den_o (d_den[i]),
      .side_o(d_side[i])
    );
  end

  // round stage: half away from zero on the magnitude
  logic [QB:0]         s6_q [3];
  logic signed [W-1:0] s6_v [3];
  logic [2:0]          s6_tneg;

  always_ff @(posedge clk) begin
    if (ld[RS]) begin
      for (int i = 0; i < 3; i++) begin
        s6_q[i]    <= (QB+1)'(d_quo[i])
                    + (QB+1)'({d_rem[i], 1'b0} >= (NW+1)'(d_den[i]));
        s6_v[i]    <= $signed(d_side[i][W-1:0]);
        s6_tneg[i] <= d_side[i][W];
      end
    end
  end

  // output stage: apply correction and saturate
  logic signed [W+3:0] r_full [3];
  logic signed [W-1:0] r_sat  [3];
  logic [2:0]          r_clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_full[i] = s6_tneg[i] ? (W+4)'(s6_v[i]) + $signed((W+4)'(s6_q[i]))
                             : (W+4)'(s6_v[i]) - $signed((W+4)'(s6_q[i]));
      r_clip[i] = 1'b1;
      if (r_full[i] > (W+4)'(MAXV)) begin
        r_sat[i] = MAXV;
      end else if (r_full[i] < (W+4)'(MINV)) begin
        r_sat[i] = MINV;
      end else begin
        r_sat[i]  = r_full[i][W-1:0];
        r_clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[S-1]) begin
      out_x   <= r_sat[0];
      out_y   <= r_sat[1];
      out_z   <= r_sat[2];
      clipped <= |r_clip;
    end
  end

endmodule
